/* src/partitioned_csr_builder_macros.svh */
// ----------------------------------------------------------------------------
// partitioned_csr_builder_macros
// Assertion macros shared by the csr builder modules.
// ----------------------------------------------------------------------------
`ifndef PARTITIONED_CSR_BUILDER_MACROS_SVH
`define PARTITIONED_CSR_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF
// concurrent check on a given clock, off while reset is active
`define PCSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pcsr assertion failed");
// same check on the usual clk_i and rst_ni
`define PCSR_ASSERT_I(lbl, prop) \
  `PCSR_ASSERT(lbl, clk_i, rst_ni, prop)
`else
`define PCSR_ASSERT(lbl, clk, rst_n, prop)
`define PCSR_ASSERT_I(lbl, prop)
`endif

`endif

/* src/pcsr_pkg.sv */
// ----------------------------------------------------------------------------
// pcsr_pkg
// Field widths, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsr_pkg;

  // fixed field widths
  localparam int NODE_W     = 9;
  localparam int NODE_CNT_W = 10;
  localparam int LANE_W     = 2;
  localparam int SLOT_W     = 12;
  localparam int NBR_W      = 7;
  localparam int CNT_W      = 13;

  // saturation value of degree counters and lane totals
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // parameter defaults
  localparam int DEF_MAX_NODES = 512;
  localparam int DEF_LANES     = 4;
  localparam int DEF_ATTR_W    = 8;

  // commands from controller to datapath
  typedef struct packed {
    logic ld_item;      // latch the accepted edge
    logic cnt_rst;      // reset the node walk counter
    logic clr_step;     // zero one degree row, advance counter
    logic deg_rd_in;    // read degree row at incoming source
    logic deg_rd_item;  // read degree row at latched source
    logic deg_wr;       // write back bumped degree row
    logic tot_clr;      // zero the lane totals
    logic pfx_step;     // prefix walk step
    logic off_rd_in;    // read offset row at incoming source
    logic off_rd_item;  // read offset row at latched source
    logic plc_commit;   // bump offset and load the result register
  } pcsr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;     // clear sweep at its last row
    logic pfx_end;      // prefix walk has covered all nodes
    logic item_valid;   // latched edge names in-range nodes
    logic out_free;     // result register can take a result
  } pcsr_sts_t;

endpackage

`default_nettype wire

/* src/partitioned_csr_builder.sv */
// Counting edge: accepted, then written back in the next cycle; input stalls outside S_IDLE.
// Counting edge opening a pass: adds a sweep over all MAX_NODES degree rows and a reread.
// Placing edge: offset read at transfer; S_PLC_WR loads the result once the output is free.
// First placing edge: adds a prefix walk over min(node_count, MAX_NODES) nodes and a reread.
// After reset the input stalls for a sweep that zeroes all MAX_NODES degree memory rows.
// ----------------------------------------------------------------------------
// partitioned_csr_builder
// Two-pass counting sort that places edges into per-lane CSR tables.
// ----------------------------------------------------------------------------
`default_nettype none

module partitioned_csr_builder
  import pcsr_pkg::*;
#(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int LANES      = DEF_LANES,
  parameter int ATTR_WIDTH = DEF_ATTR_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [NODE_CNT_W-1:0] cfg_wdata_i,
  // edge input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  func_i,
  input  wire logic                  first_of_pass_i,
  input  wire logic [NODE_W-1:0]     src_node_i,
  input  wire logic [NODE_W-1:0]     dst_node_i,
  input  wire logic [ATTR_WIDTH-1:0] edge_attr_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [LANE_W-1:0]     lane_o,
  output logic      [SLOT_W-1:0]     slot_o,
  output logic      [NBR_W-1:0]      neighbour_local_o,
  output logic      [ATTR_WIDTH-1:0] attr_out_o,
  output logic      [CNT_W-1:0]      lane_total_o
);

  pcsr_cmd_t cmd;
  pcsr_sts_t sts;

  // sequencer
  pcsr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .func_i          (func_i),
    .first_of_pass_i (first_of_pass_i),
    .in_stall_o      (in_stall_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // memories, totals and result register
  pcsr_dpath #(
    .MAX_NODES  (MAX_NODES),
    .LANES      (LANES),
    .ATTR_WIDTH (ATTR_WIDTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .src_node_i        (src_node_i),
    .dst_node_i        (dst_node_i),
    .edge_attr_i       (edge_attr_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .lane_o            (lane_o),
    .slot_o            (slot_o),
    .neighbour_local_o (neighbour_local_o),
    .attr_out_o        (attr_out_o),
    .lane_total_o      (lane_total_o)
  );

endmodule

`default_nettype wire

/* src/pcsr_ram.sv */
// ----------------------------------------------------------------------------
// pcsr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/pcsr_ctrl.sv */
// ----------------------------------------------------------------------------
// pcsr_ctrl
// Sequencer: clear sweeps, counting and placing edges, prefix walk.
// ----------------------------------------------------------------------------
`default_nettype none

`include "partitioned_csr_builder_macros.svh"

module pcsr_ctrl
  import pcsr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      func_i,
  input  wire logic      first_of_pass_i,
  output logic           in_stall_o,
  input  wire pcsr_sts_t sts_i,
  output pcsr_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CNT_RD = 7'b0000100,
    S_CNT_WR = 7'b0001000,
    S_PFX    = 7'b0010000,
    S_PLC_RD = 7'b0100000,
    S_PLC_WR = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   offs_ready_q, offs_ready_d;
  logic   ret_cnt_q, ret_cnt_d;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    offs_ready_d = offs_ready_q;
    ret_cnt_d    = ret_cnt_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ret_cnt_q ? S_CNT_RD : S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          if (!func_i) begin
            offs_ready_d = 1'b0;
            if (first_of_pass_i) begin
              cmd_o.cnt_rst = 1'b1;
              ret_cnt_d     = 1'b1;
              state_d       = S_CLEAR;
            end else begin
              cmd_o.deg_rd_in = 1'b1;
              state_d         = S_CNT_WR;
            end
          end else if (first_of_pass_i || !offs_ready_q) begin
            cmd_o.cnt_rst = 1'b1;
            cmd_o.tot_clr = 1'b1;
            state_d       = S_PFX;
          end else begin
            cmd_o.off_rd_in = 1'b1;
            state_d         = S_PLC_WR;
          end
        end
      end
      S_CNT_RD: begin
        cmd_o.deg_rd_item = 1'b1;
        ret_cnt_d         = 1'b0;
        state_d           = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd_o.deg_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_PFX: begin
        cmd_o.pfx_step = 1'b1;
        if (sts_i.pfx_end) begin
          offs_ready_d = 1'b1;
          state_d      = S_PLC_RD;
        end
      end
      S_PLC_RD: begin
        cmd_o.off_rd_item = 1'b1;
        state_d           = S_PLC_WR;
      end
      S_PLC_WR: begin
        if (!sts_i.item_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.plc_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // state registers; reset starts with a full clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      offs_ready_q <= 1'b0;
      ret_cnt_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      offs_ready_q <= offs_ready_d;
      ret_cnt_q    <= ret_cnt_d;
    end
  end

  // a placing edge is only resolved against finished offsets
  `PCSR_ASSERT_I(a_plc_after_prefix, (state_q == S_PLC_WR) |-> offs_ready_q)
  // offsets become ready only out of a prefix walk
  `PCSR_ASSERT_I(a_ready_from_pfx, $rose(offs_ready_q) |-> $past(state_q == S_PFX))
  // a result is never committed over an untaken one
  `PCSR_ASSERT_I(a_commit_free, cmd_o.plc_commit |-> sts_i.out_free)

endmodule

`default_nettype wire

/* src/pcsr_dpath.sv */
// ----------------------------------------------------------------------------
// pcsr_dpath
// Degree and offset memories, lane totals, edge latch and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "partitioned_csr_builder_macros.svh"

module pcsr_dpath
  import pcsr_pkg::*;
#(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int LANES      = DEF_LANES,
  parameter int ATTR_WIDTH = DEF_ATTR_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [NODE_CNT_W-1:0] cfg_wdata_i,
  input  wire logic [NODE_W-1:0]     src_node_i,
  input  wire logic [NODE_W-1:0]     dst_node_i,
  input  wire logic [ATTR_WIDTH-1:0] edge_attr_i,
  input  wire pcsr_cmd_t             cmd_i,
  output pcsr_sts_t                  sts_o,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic      [LANE_W-1:0]     lane_o,
  output logic      [SLOT_W-1:0]     slot_o,
  output logic      [NBR_W-1:0]      neighbour_local_o,
  output logic      [ATTR_WIDTH-1:0] attr_out_o,
  output logic      [CNT_W-1:0]      lane_total_o
);

  localparam int AW     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int DEG_RW = LANES * CNT_W;
  localparam int OFF_RW = LANES * SLOT_W;
  // reciprocal for dst / LANES, exact for 9-bit operands
  localparam int QK     = 24;
  localparam int PW     = QK + NODE_W + 1;
  localparam logic [QK:0] RECIP = (QK + 1)'(((1 << QK) + LANES - 1) / LANES);

  // configuration
  logic [NODE_CNT_W-1:0] node_count_q;
  logic [CW-1:0]         act_n;

  // latched edge
  logic [NODE_W-1:0]     src_q, dst_q, quo_q;
  logic [ATTR_WIDTH-1:0] attr_q;
  logic [PW-1:0]         quo_prod;
  logic [NODE_W-1:0]     quo_mul;
  logic [LW-1:0]         lane_idx;
  logic                  item_valid;

  // node walk
  logic [CW-1:0]         cnt_q;
  logic                  pfx_end, pfx_rd;
  logic                  pfx_pend_q;
  logic [AW-1:0]         pfx_addr_q;

  // memories
  logic                  deg_we, deg_re;
  logic [AW-1:0]         deg_waddr, deg_raddr;
  logic [DEG_RW-1:0]     deg_wdata, deg_rdata, deg_bump;
  logic [CNT_W-1:0]      deg_old;
  logic                  off_we, off_re;
  logic [AW-1:0]         off_waddr, off_raddr;
  logic [OFF_RW-1:0]     off_wdata, off_rdata, off_bump, pfx_row;
  logic [SLOT_W-1:0]     off_old;

  // lane totals
  logic [CNT_W-1:0]      tot_q [LANES];
  logic [CNT_W-1:0]      tot_d [LANES];
  logic [CNT_W:0]        pfx_sum [LANES];

  // result register
  logic                  out_valid_q, out_free;
  logic [LANE_W-1:0]     res_lane_q;
  logic [SLOT_W-1:0]     res_slot_q;
  logic [NBR_W-1:0]      res_nbr_q;
  logic [ATTR_WIDTH-1:0] res_attr_q;
  logic [CNT_W-1:0]      res_total_q;

  // node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  assign act_n = (32'(node_count_q) >= MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_q);

  // edge latch, quotient by reciprocal multiply
  assign quo_prod = PW'(dst_node_i) * PW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      src_q  <= src_node_i;
      dst_q  <= dst_node_i;
      quo_q  <= quo_prod[QK +: NODE_W];
      attr_q <= edge_attr_i;
    end
  end

  // lane as remainder of the latched quotient
  assign quo_mul    = NODE_W'(quo_q * NODE_W'(LANES));
  assign lane_idx   = LW'(dst_q - quo_mul);
  assign item_valid = (32'(src_q) < 32'(act_n)) && (32'(dst_q) < 32'(act_n));

  // node walk counter for clear sweeps and prefix
  assign pfx_end = (cnt_q >= act_n);
  assign pfx_rd  = cmd_i.pfx_step && !pfx_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pfx_pend_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_rst) begin
        cnt_q <= '0;
      end else if (cmd_i.clr_step || pfx_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
      pfx_pend_q <= pfx_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    pfx_addr_q <= cnt_q[AW-1:0];
  end

  // degree row update for a counting edge
  always_comb begin
    deg_old                            = deg_rdata[lane_idx*CNT_W +: CNT_W];
    deg_bump                           = deg_rdata;
    deg_bump[lane_idx*CNT_W +: CNT_W]  = deg_old + 1'b1;
  end

  // degree memory port control
  assign deg_we    = cmd_i.clr_step || (cmd_i.deg_wr && item_valid && (deg_old != CNT_MAX));
  assign deg_waddr = cmd_i.clr_step ? cnt_q[AW-1:0] : AW'(src_q);
  assign deg_wdata = cmd_i.clr_step ? '0 : deg_bump;
  assign deg_re    = cmd_i.deg_rd_in || cmd_i.deg_rd_item || pfx_rd;
  assign deg_raddr = cmd_i.deg_rd_in ? AW'(src_node_i) :
                     (pfx_rd ? cnt_q[AW-1:0] : AW'(src_q));

  pcsr_ram #(
    .WIDTH (DEG_RW),
    .DEPTH (MAX_NODES)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .re_i    (deg_re),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  // prefix step: offsets from running totals, saturating accumulate
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pfx_sum[l]                  = {1'b0, tot_q[l]} + {1'b0, deg_rdata[l*CNT_W +: CNT_W]};
      tot_d[l]                    = (pfx_sum[l] > {1'b0, CNT_MAX}) ? CNT_MAX
                                                                   : pfx_sum[l][CNT_W-1:0];
      pfx_row[l*SLOT_W +: SLOT_W] = tot_q[l][SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LANES; l++) begin
        tot_q[l] <= '0;
      end
    end else if (cmd_i.tot_clr) begin
      for (int l = 0; l < LANES; l++) begin
        tot_q[l] <= '0;
      end
    end else if (pfx_pend_q) begin
      for (int l = 0; l < LANES; l++) begin
        tot_q[l] <= tot_d[l];
      end
    end
  end

  // offset row update for a placing edge, slot wraps
  always_comb begin
    off_old                             = off_rdata[lane_idx*SLOT_W +: SLOT_W];
    off_bump                            = off_rdata;
    off_bump[lane_idx*SLOT_W +: SLOT_W] = off_old + 1'b1;
  end

  // offset memory port control
  assign off_we    = pfx_pend_q || cmd_i.plc_commit;
  assign off_waddr = pfx_pend_q ? pfx_addr_q : AW'(src_q);
  assign off_wdata = pfx_pend_q ? pfx_row : off_bump;
  assign off_re    = cmd_i.off_rd_in || cmd_i.off_rd_item;
  assign off_raddr = cmd_i.off_rd_in ? AW'(src_node_i) : AW'(src_q);

  pcsr_ram #(
    .WIDTH (OFF_RW),
    .DEPTH (MAX_NODES)
  ) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .re_i    (off_re),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  // result register, takes a new result once the old transfer is done
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.plc_commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plc_commit) begin
      res_lane_q  <= LANE_W'(lane_idx);
      res_slot_q  <= off_old;
      res_nbr_q   <= NBR_W'(quo_q);
      res_attr_q  <= attr_q;
      res_total_q <= tot_q[lane_idx];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign lane_o            = res_lane_q;
  assign slot_o            = res_slot_q;
  assign neighbour_local_o = res_nbr_q;
  assign attr_out_o        = res_attr_q;
  assign lane_total_o      = res_total_q;

  // status back to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (cnt_q == CW'(MAX_NODES - 1));
    sts_o.pfx_end    = pfx_end;
    sts_o.item_valid = item_valid;
    sts_o.out_free   = out_free;
  end

  // a commit always leaves a result pending
  `PCSR_ASSERT_I(a_commit_loads, cmd_i.plc_commit |=> out_valid_q)
  // clear sweep never runs past the last row
  `PCSR_ASSERT_I(a_clr_in_range, cmd_i.clr_step |-> (cnt_q < CW'(MAX_NODES)))
  // prefix writes and placing writes never share the offset write port
  `PCSR_ASSERT_I(a_off_port_free, pfx_pend_q |-> !cmd_i.plc_commit)

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the partitioned csr builder. A cycle-free model
// of the two-pass counting sort follows every accepted edge and queues the
// placement it should yield; each output transfer is checked field by field
// against the oldest queued placement. Directed edges, an output hold-off
// and random graphs are driven under random idling.
// ----------------------------------------------------------------------------
module tb_top;
  import pcsr_pkg::*;

  localparam int NODES         = DEF_MAX_NODES;
  localparam int NUM_LANES     = DEF_LANES;
  localparam int ATTR_W        = DEF_ATTR_W;
  localparam int SETTLE_CYCLES = DEF_MAX_NODES + 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_LIMIT   = 3000;
  localparam int RANDOM_EDGES  = 970;

  // edge kinds on func_i
  localparam logic EDGE_COUNT = 1'b0;
  localparam logic EDGE_PLACE = 1'b1;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [SLOT_W-1:0] slot;
    logic [NBR_W-1:0]  nbr;
    logic [ATTR_W-1:0] attr;
    logic [CNT_W-1:0]  total;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [NODE_CNT_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  func = EDGE_COUNT;
  logic                  first_of_pass = 1'b0;
  logic [NODE_W-1:0]     src_node = '0;
  logic [NODE_W-1:0]     dst_node = '0;
  logic [ATTR_W-1:0]     edge_attr = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [LANE_W-1:0]     lane;
  logic [SLOT_W-1:0]     slot;
  logic [NBR_W-1:0]      neighbour_local;
  logic [ATTR_W-1:0]     attr_out;
  logic [CNT_W-1:0]      lane_total;

  // sort model state
  logic [CNT_W-1:0]      deg_tbl [NUM_LANES][NODES];
  logic [SLOT_W-1:0]     off_tbl [NUM_LANES][NODES];
  logic [CNT_W-1:0]      lane_sum [NUM_LANES];
  bit                    offs_valid = 1'b0;
  logic [NODE_CNT_W-1:0] node_cnt_q = '0;
  placement_t            placements_due [$];
  placement_t            head_p;

  // bookkeeping
  int  mismatches = 0;
  int  edges_sent = 0;
  int  count_edges = 0;
  int  place_edges = 0;
  int  placements_seen = 0;
  int  cfg_writes = 0;
  bit  quiet = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  rx_gap;

  partitioned_csr_builder dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .func_i            (func),
    .first_of_pass_i   (first_of_pass),
    .src_node_i        (src_node),
    .dst_node_i        (dst_node),
    .edge_attr_i       (edge_attr),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .lane_o            (lane),
    .slot_o            (slot),
    .neighbour_local_o (neighbour_local),
    .attr_out_o        (attr_out),
    .lane_total_o      (lane_total)
  );

  // clock and reset
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // sort model
  // ---------------------------------------------------------------------------
  function automatic int active_nodes();
    return (node_cnt_q < NODES) ? int'(node_cnt_q) : NODES;
  endfunction

  // exclusive prefix sums over the active nodes, lane totals saturate
  function automatic void build_lane_offsets();
    int act;
    int sum;
    act = active_nodes();
    for (int l = 0; l < NUM_LANES; l++) lane_sum[l] = '0;
    for (int i = 0; i < act; i++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        off_tbl[l][i] = lane_sum[l][SLOT_W-1:0];
        sum = int'(lane_sum[l]) + int'(deg_tbl[l][i]);
        lane_sum[l] = (sum > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);
      end
    end
    offs_valid = 1'b1;
  endfunction

  // one accepted edge: count it, or place it and queue the placement
  function automatic void csr_sort_step(logic f, logic opens, logic [NODE_W-1:0] src,
                                        logic [NODE_W-1:0] dst, logic [ATTR_W-1:0] a);
    int         act;
    bit         in_range;
    int         ln;
    placement_t p;
    act = active_nodes();
    in_range = (src < act) && (dst < act);
    ln = dst % NUM_LANES;
    if (f == EDGE_COUNT) begin
      if (opens) begin
        for (int l = 0; l < NUM_LANES; l++)
          for (int i = 0; i < NODES; i++) deg_tbl[l][i] = '0;
      end
      offs_valid = 1'b0;
      if (in_range && deg_tbl[ln][src] != CNT_MAX) deg_tbl[ln][src] = deg_tbl[ln][src] + 1'b1;
    end else begin
      if (opens || !offs_valid) build_lane_offsets();
      if (in_range) begin
        p.lane  = LANE_W'(ln);
        p.slot  = off_tbl[ln][src];
        p.nbr   = NBR_W'(dst / NUM_LANES);
        p.attr  = a;
        p.total = lane_sum[ln];
        off_tbl[ln][src] = off_tbl[ln][src] + 1'b1;
        placements_due.push_back(p);
      end
    end
  endfunction

  initial begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_sum[l] = '0;
      for (int i = 0; i < NODES; i++) begin
        deg_tbl[l][i] = '0;
        off_tbl[l][i] = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // output transfer checked first, then the input transfer feeds the model
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        placements_seen++;
        if (placements_due.size() == 0) begin
          report($sformatf("placement with none pending: lane %0d slot %0d", lane, slot));
        end else begin
          head_p = placements_due.pop_front();
          if (lane !== head_p.lane)
            report($sformatf("lane %0d, expected %0d", lane, head_p.lane));
          if (slot !== head_p.slot)
            report($sformatf("slot %0d, expected %0d", slot, head_p.slot));
          if (neighbour_local !== head_p.nbr)
            report($sformatf("neighbour_local %0d, expected %0d", neighbour_local,
                             head_p.nbr));
          if (attr_out !== head_p.attr)
            report($sformatf("attr_out %0h, expected %0h", attr_out, head_p.attr));
          if (lane_total !== head_p.total)
            report($sformatf("lane_total %0d, expected %0d", lane_total, head_p.total));
        end
      end
      if (in_valid && !in_stall) begin
        edges_sent++;
        if (func == EDGE_COUNT) count_edges++;
        else place_edges++;
        csr_sort_step(func, first_of_pass, src_node, dst_node, edge_attr);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("partitioned_csr_builder verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls: forced hold-off first, then random gaps
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      rx_gap = quiet ? 0 : pick_gap();
      out_stall <= (rx_gap > 0);
      stall_left = (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_edge(input logic f, input logic opens, input logic [NODE_W-1:0] src,
                           input logic [NODE_W-1:0] dst, input logic [ATTR_W-1:0] a);
    int g;
    func          <= f;
    first_of_pass <= opens;
    src_node      <= src;
    dst_node      <= dst;
    edge_attr     <= a;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_noise();
    send_edge(logic'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
              NODE_W'($urandom_range(0, NODES - 1)), NODE_W'($urandom_range(0, NODES - 1)),
              ATTR_W'($urandom_range(0, 255)));
  endtask

  // wait for all placements, then for any walk still in progress
  task automatic settle();
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_node_count(input logic [NODE_CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    node_cnt_q = v;
    cfg_writes++;
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    int act;
    act = active_nodes();
    if (act == 0 || $urandom_range(0, 15) == 0) return NODE_W'($urandom_range(0, NODES - 1));
    return NODE_W'($urandom_range(0, act - 1));
  endfunction

  function automatic logic [NODE_CNT_W-1:0] pick_node_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return NODE_CNT_W'($urandom_range(1, 24));
    if (r < 70) return NODE_CNT_W'($urandom_range(25, 100));
    if (r < 80) return NODE_CNT_W'(NODES);
    if (r < 88) return NODE_CNT_W'($urandom_range(NODES + 1, 1023));
    if (r < 94) return '1;
    return NODE_CNT_W'($urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, pass restarts, out-of-range nodes and an empty graph
  task automatic test_directed();
    settle();
    write_node_count('1);
    send_edge(EDGE_COUNT, 1'b1, 9'd511, 9'd511, 8'hff);
    send_edge(EDGE_COUNT, 1'b0, 9'd0, 9'd0, 8'h00);
    send_edge(EDGE_COUNT, 1'b0, 9'd511, 9'd0, 8'h5a);
    send_edge(EDGE_COUNT, 1'b0, 9'd0, 9'd511, 8'ha5);
    send_edge(EDGE_COUNT, 1'b0, 9'd511, 9'd511, 8'h3c);
    send_edge(EDGE_PLACE, 1'b1, 9'd511, 9'd511, 8'hff);
    send_edge(EDGE_PLACE, 1'b0, 9'd0, 9'd0, 8'h00);
    send_edge(EDGE_PLACE, 1'b0, 9'd511, 9'd0, 8'h5a);
    send_edge(EDGE_PLACE, 1'b0, 9'd0, 9'd511, 8'ha5);
    send_edge(EDGE_PLACE, 1'b0, 9'd511, 9'd511, 8'h3c);
    // reopening the placing pass rebuilds the offsets
    send_edge(EDGE_PLACE, 1'b1, 9'd0, 9'd0, 8'h81);
    // a counting edge drops the offsets, so a plain placing edge rebuilds them
    send_edge(EDGE_COUNT, 1'b0, 9'd1, 9'd2, 8'h12);
    send_edge(EDGE_PLACE, 1'b0, 9'd1, 9'd2, 8'h34);
    settle();
    write_node_count(10'd5);
    send_edge(EDGE_COUNT, 1'b1, 9'd5, 9'd0, 8'h01);
    send_edge(EDGE_COUNT, 1'b0, 9'd0, 9'd5, 8'h02);
    send_edge(EDGE_COUNT, 1'b0, 9'd4, 9'd3, 8'h03);
    send_edge(EDGE_PLACE, 1'b1, 9'd9, 9'd1, 8'h04);
    send_edge(EDGE_PLACE, 1'b0, 9'd4, 9'd3, 8'h05);
    send_edge(EDGE_PLACE, 1'b0, 9'd4, 9'd300, 8'h06);
    settle();
    write_node_count('0);
    send_edge(EDGE_COUNT, 1'b1, 9'd0, 9'd0, 8'h07);
    send_edge(EDGE_PLACE, 1'b1, 9'd0, 9'd0, 8'h08);
    settle();
    write_node_count(10'd512);
    send_edge(EDGE_COUNT, 1'b1, 9'd256, 9'd255, 8'haa);
    send_edge(EDGE_PLACE, 1'b1, 9'd256, 9'd255, 8'h55);
  endtask

  // long output hold-off while placing edges keep coming
  task automatic test_backpressure();
    logic [NODE_W-1:0] src_l [48];
    logic [NODE_W-1:0] dst_l [48];
    settle();
    write_node_count(10'd16);
    for (int i = 0; i < 48; i++) begin
      src_l[i] = pick_node();
      dst_l[i] = pick_node();
      send_edge(EDGE_COUNT, (i == 0), src_l[i], dst_l[i], ATTR_W'($urandom_range(0, 255)));
    end
    quiet = 1'b1;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 48; i++)
      send_edge(EDGE_PLACE, (i == 0), src_l[i], dst_l[i], ATTR_W'($urandom_range(0, 255)));
    quiet = 1'b0;
  endtask

  // random graphs: two well-formed passes with noise and restarts mixed in
  task automatic test_random_graphs();
    logic [NODE_W-1:0] src_l [64];
    logic [NODE_W-1:0] dst_l [64];
    logic [ATTR_W-1:0] attr_l [64];
    int                order [64];
    int                start;
    int                ne;
    int                j;
    int                tmp;
    bit                opens;
    start = edges_sent;
    while (edges_sent - start < RANDOM_EDGES) begin
      if (edges_sent == start || $urandom_range(0, 2) == 0) begin
        settle();
        write_node_count(pick_node_count());
      end
      quiet = ($urandom_range(0, 3) == 0);
      ne = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 64) : $urandom_range(1, 30);
      for (int i = 0; i < ne; i++) begin
        src_l[i]  = pick_node();
        dst_l[i]  = pick_node();
        attr_l[i] = ATTR_W'($urandom_range(0, 255));
        order[i]  = i;
      end
      // counting pass; sometimes it does not open, so degrees pile up
      opens = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < ne; i++) begin
        if (i > 0 && $urandom_range(0, 11) == 0) send_noise();
        send_edge(EDGE_COUNT, opens && (i == 0), src_l[i], dst_l[i], attr_l[i]);
      end
      // placing pass in original or shuffled order
      if ($urandom_range(0, 1) == 1) begin
        for (int i = ne - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
      end
      opens = ($urandom_range(0, 5) != 0);
      for (int i = 0; i < ne; i++) begin
        if (i > 0 && $urandom_range(0, 15) == 0) send_noise();
        send_edge(EDGE_PLACE, opens && (i == 0), src_l[order[i]], dst_l[order[i]],
                  attr_l[order[i]]);
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    waited = 0;
    @(posedge rst_n);
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random_graphs();
    in_valid <= 1'b0;
    while (placements_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (placements_due.size() != 0)
      report($sformatf("%0d placements never arrived", placements_due.size()));
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("run: %0d edge transfers (%0d counting, %0d placing), %0d placements checked",
             edges_sent, count_edges, place_edges, placements_seen);
    $display("run: %0d node_count writes, pass restarts, %0d-cycle output hold",
             cfg_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("partitioned_csr_builder verification clean");
    end else begin
      $display("partitioned_csr_builder verification failed");
    end
    $finish;
  end

endmodule
